FILE: hdl/ect_pkg.sv
// Event counter table: shared types and constants.
// Operation and status codes, table entry layout, controller states.
// No dependencies.
package ect_pkg;

   typedef enum logic [1:0] {
      MODE_CREATE = 2'd0,
      MODE_READ   = 2'd1,
      MODE_WRITE  = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_NO_SLOT     = 3'd1,
      STATUS_INVALID     = 3'd2,
      STATUS_WOULD_BLOCK = 3'd3,
      STATUS_RETRY       = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   // one table entry: counter plus the flags fixed at create
   typedef struct packed {
      logic        semaphore;
      logic        nonblocking;
      logic [63:0] count;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   localparam logic [63:0] COUNT_MAX = 64'hffff_ffff_ffff_fffe;
   localparam logic [3:0]  MIN_LEN   = 4'd8;

endpackage

FILE: hdl/ect_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered; a read after a write sees it.
// No dependencies.
module ect_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/event_counter_table_core.sv
// Event counter table core: a pool of SLOTS event counters with eventfd rules.
// Depends on ect_pkg and ect_ram.
//
// Usage:
//   Request channel (req_*): one operation per transfer - create, read, write
//   or query - with its handle, value, create flags and buffer length.
//   Response channel (rsp_*): exactly one result per request, in order, with
//   status, the new handle of a create, the value of a read and the query
//   flags readable / writable.
//
// Timing:
//   Every request reads one entry of the counter RAM; a successful create,
//   read or write then writes it back. Its result is loaded into the
//   response register at the end of execute, after the RAM read state.
//   The next request is taken in the execute state, so a new request is
//   not accepted before the last one has reached execute; the single RAM
//   read port sets this limit. A response waiting in the output register
//   blocks acceptance only while it is stalled and a request in execute
//   holds there until the response is transferred.
//
// Reset empties the table at once: slots are handed out lowest first and
// never freed, so a fill count marks which slots are live and the RAM needs
// no clearing.
module event_counter_table_core
   import ect_pkg::*;
#(
   parameter int unsigned SLOTS       = 64,
   parameter int unsigned HANDLE_BASE = 256
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_handle,
   input  logic [63:0] req_value,
   input  logic [1:0]  req_open_flags,
   input  logic [3:0]  req_length_bytes,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_new_handle,
   output logic [63:0] rsp_read_value,
   output logic        rsp_readable,
   output logic        rsp_writable
);

   localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CNT_W = $clog2(SLOTS + 1);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;

   mode_type           mode_ff;
   logic [63:0]        value_ff;
   logic [1:0]         flags_ff;
   logic               len_ok_ff;
   logic               all_ones_ff;
   logic               hit_ff;
   logic [IDX_W-1:0]   idx_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic [15:0]        new_handle_ff, new_handle_in;
   logic [63:0]        read_value_ff, read_value_in;
   logic               readable_ff, readable_in;
   logic               writable_ff, writable_in;

   logic               req_accept;
   logic               exec_done;
   logic [16:0]        offset;
   logic               hit_in;
   logic [IDX_W-1:0]   idx_in;

   logic [ENTRY_W-1:0] rd_data;
   entry_type          entry_rd;
   entry_type          entry_wr;
   logic               wr_en;
   logic [64:0]        sum;

   // ---------------------------------------------------------------- control
   assign exec_done  = (state_ff == ST_EXEC) && !(rsp_valid_ff && rsp_stall);
   assign req_stall  = !((state_ff == ST_IDLE) || exec_done);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_READ;
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            if (exec_done) state_in = req_accept ? ST_READ : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handle decode at transfer time, against the fill count after any create
   // that commits in the same cycle
   assign offset = {1'b0, req_handle} - 17'(HANDLE_BASE);

   always_comb begin
      if (mode_type'(req_mode) == MODE_CREATE) begin
         hit_in = (fill_in != CNT_W'(SLOTS));
         idx_in = fill_in[IDX_W-1:0];
      end else begin
         hit_in = ({1'b0, req_handle} >= 17'(HANDLE_BASE)) &&
                  (offset < 17'(fill_in));
         idx_in = offset[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff     <= mode_type'(req_mode);
         value_ff    <= req_value;
         flags_ff    <= req_open_flags;
         len_ok_ff   <= (req_length_bytes >= MIN_LEN);
         all_ones_ff <= &req_value;
         hit_ff      <= hit_in;
         idx_ff      <= idx_in;
      end
   end

   // ------------------------------------------------------------ counter RAM
   ect_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (entry_wr),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign entry_rd = entry_type'(rd_data);
   assign sum      = {1'b0, entry_rd.count} + {1'b0, value_ff};

   // ---------------------------------------------------------------- execute
   always_comb begin
      wr_en         = 1'b0;
      entry_wr      = entry_rd;
      fill_in       = fill_ff;
      status_in     = STATUS_OK;
      new_handle_in = '0;
      read_value_in = '0;
      readable_in   = 1'b0;
      writable_in   = 1'b0;

      unique case (mode_ff)
         MODE_CREATE: begin
            if (!hit_ff) begin
               status_in = STATUS_NO_SLOT;
            end else begin
               wr_en                = 1'b1;
               entry_wr.count       = {32'd0, value_ff[31:0]};
               entry_wr.nonblocking = flags_ff[0];
               entry_wr.semaphore   = flags_ff[1];
               fill_in              = fill_ff + CNT_W'(1);
               new_handle_in        = 16'(HANDLE_BASE) + 16'(idx_ff);
            end
         end
         MODE_READ: begin
            if (!hit_ff || !len_ok_ff) begin
               status_in = STATUS_INVALID;
            end else if (entry_rd.count == '0) begin
               status_in = entry_rd.nonblocking ? STATUS_WOULD_BLOCK : STATUS_RETRY;
            end else if (entry_rd.semaphore) begin
               wr_en          = 1'b1;
               read_value_in  = 64'd1;
               entry_wr.count = entry_rd.count - 64'd1;
            end else begin
               wr_en          = 1'b1;
               read_value_in  = entry_rd.count;
               entry_wr.count = '0;
            end
         end
         MODE_WRITE: begin
            if (!hit_ff || !len_ok_ff || all_ones_ff) begin
               status_in = STATUS_INVALID;
            end else if (sum > {1'b0, COUNT_MAX}) begin
               status_in = entry_rd.nonblocking ? STATUS_WOULD_BLOCK : STATUS_RETRY;
            end else begin
               wr_en          = 1'b1;
               entry_wr.count = sum[63:0];
            end
         end
         MODE_QUERY: begin
            if (!hit_ff) begin
               status_in = STATUS_INVALID;
            end else begin
               readable_in = (entry_rd.count != '0);
               writable_in = (entry_rd.count < COUNT_MAX);
            end
         end
         default: status_in = STATUS_INVALID;
      endcase

      // nothing is committed until the result register can take the response
      if (!exec_done) begin
         wr_en   = 1'b0;
         fill_in = fill_ff;
      end
   end

   // -------------------------------------------------------- response output
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (exec_done)                  rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (exec_done) begin
         status_ff     <= status_in;
         new_handle_ff <= new_handle_in;
         read_value_ff <= read_value_in;
         readable_ff   <= readable_in;
         writable_ff   <= writable_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_new_handle = new_handle_ff;
   assign rsp_read_value = read_value_ff;
   assign rsp_readable   = readable_ff;
   assign rsp_writable   = writable_ff;

endmodule

FILE: tb/tb.sv
// Testbench for event_counter_table_core: a short table of directed requests, then
// random create/read/write/query traffic; replies checked by predictor or table.
// Depends on ect_pkg and event_counter_table_core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ect_pkg::*;

   localparam int SLOTS       = 64;
   localparam int HANDLE_BASE = 256;
   localparam int N_RANDOM    = 2000;
   localparam int IDLE_PCT    = 29;

   typedef struct packed {
      mode_type    mode;
      logic [15:0] handle;
      logic [63:0] value;
      logic [1:0]  open_flags;
      logic [3:0]  length_bytes;
   } counter_req_t;

   typedef struct packed {
      status_type  status;
      logic [15:0] new_handle;
      logic [63:0] read_value;
      logic        readable;
      logic        writable;
   } counter_reply_t;

   typedef struct {
      counter_req_t   req;
      bit             typed;
      counter_reply_t want;
   } dir_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = '0;
   logic [15:0] req_handle = '0;
   logic [63:0] req_value = '0;
   logic [1:0]  req_open_flags = '0;
   logic [3:0]  req_length_bytes = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_new_handle;
   logic [63:0] rsp_read_value;
   logic        rsp_readable;
   logic        rsp_writable;

   // predictor copy of the counter table
   logic        slot_live   [SLOTS];
   logic [63:0] slot_count  [SLOTS];
   logic        slot_nonblk [SLOTS];
   logic        slot_sem    [SLOTS];
   int unsigned slots_used = 0;

   counter_reply_t replies_due[$];
   dir_row_t       dir_rows[$];
   bit             typed_now = 1'b0;
   counter_reply_t want_now = '0;
   bit             calm = 1'b0;
   int             errors = 0;

   event_counter_table_core #(
      .SLOTS      (SLOTS),
      .HANDLE_BASE(HANDLE_BASE)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_handle      (req_handle),
      .req_value       (req_value),
      .req_open_flags  (req_open_flags),
      .req_length_bytes(req_length_bytes),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_new_handle  (rsp_new_handle),
      .rsp_read_value  (rsp_read_value),
      .rsp_readable    (rsp_readable),
      .rsp_writable    (rsp_writable)
   );

   always #1 clock = ~clock;

   function automatic status_type busy_status(input int slot);
      if (slot_nonblk[slot])
         return STATUS_WOULD_BLOCK;
      return STATUS_RETRY;
   endfunction

   // applies one request to the table copy and returns its reply
   function automatic counter_reply_t counter_table_op(input counter_req_t r);
      counter_reply_t rep;
      int             slot;
      rep = '0;
      slot = -1;
      if (r.handle >= HANDLE_BASE && r.handle < HANDLE_BASE + SLOTS &&
          slot_live[r.handle - HANDLE_BASE] === 1'b1)
         slot = int'(r.handle) - HANDLE_BASE;
      case (r.mode)
         MODE_CREATE: begin
            // slots are never freed, so the lowest free one is the fill count
            if (slots_used == SLOTS) begin
               rep.status = STATUS_NO_SLOT;
            end else begin
               slot_live[slots_used]   = 1'b1;
               slot_count[slots_used]  = {32'd0, r.value[31:0]};
               slot_nonblk[slots_used] = r.open_flags[0];
               slot_sem[slots_used]    = r.open_flags[1];
               rep.new_handle = 16'(HANDLE_BASE + slots_used);
               slots_used++;
            end
         end
         MODE_READ: begin
            if (slot < 0 || r.length_bytes < MIN_LEN) begin
               rep.status = STATUS_INVALID;
            end else if (slot_count[slot] == 64'd0) begin
               rep.status = busy_status(slot);
            end else if (slot_sem[slot]) begin
               rep.read_value = 64'd1;
               slot_count[slot] = slot_count[slot] - 64'd1;
            end else begin
               rep.read_value = slot_count[slot];
               slot_count[slot] = 64'd0;
            end
         end
         MODE_WRITE: begin
            if (slot < 0 || r.length_bytes < MIN_LEN || r.value == '1)
               rep.status = STATUS_INVALID;
            else if (COUNT_MAX - slot_count[slot] < r.value)
               rep.status = busy_status(slot);
            else
               slot_count[slot] = slot_count[slot] + r.value;
         end
         default: begin
            if (slot < 0) begin
               rep.status = STATUS_INVALID;
            end else begin
               rep.readable = (slot_count[slot] != 64'd0);
               rep.writable = (slot_count[slot] < COUNT_MAX);
            end
         end
      endcase
      return rep;
   endfunction

   function automatic logic [63:0] random_amount();
      case ($urandom_range(0, 7))
         0: return 64'd0;
         1: return 64'($urandom_range(1, 16));
         2: return '1;
         3: return COUNT_MAX - 64'($urandom_range(0, 3));
         4: return 64'd1 << $urandom_range(0, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // mostly live handles with random content; some unknown or boundary handles
   function automatic counter_req_t random_request();
      counter_req_t r;
      int unsigned  pick;
      pick = $urandom_range(0, 99);
      if (pick < 8)
         r.mode = MODE_CREATE;
      else if (pick < 40)
         r.mode = MODE_READ;
      else if (pick < 75)
         r.mode = MODE_WRITE;
      else
         r.mode = MODE_QUERY;
      pick = $urandom_range(0, 99);
      if (pick < 80 && slots_used > 0)
         r.handle = 16'(HANDLE_BASE + $urandom_range(0, slots_used - 1));
      else if (pick < 88)
         r.handle = 16'(HANDLE_BASE + $urandom_range(0, SLOTS - 1));
      else if (pick < 94)
         r.handle = 16'($urandom);
      else if (pick < 97)
         r.handle = 16'(HANDLE_BASE - 1);
      else
         r.handle = 16'(HANDLE_BASE + SLOTS);
      r.value = random_amount();
      r.open_flags = 2'($urandom);
      if ($urandom_range(0, 9) == 0)
         r.length_bytes = 4'($urandom);
      else
         r.length_bytes = 4'($urandom_range(8, 15));
      return r;
   endfunction

   task automatic add_row(input mode_type m, input logic [15:0] h, input logic [63:0] v,
                          input logic [1:0] f, input logic [3:0] len, input bit typed,
                          input status_type st, input logic [15:0] nh);
      dir_row_t row;
      row.req.mode = m;
      row.req.handle = h;
      row.req.value = v;
      row.req.open_flags = f;
      row.req.length_bytes = len;
      row.typed = typed;
      row.want = '0;
      row.want.status = st;
      row.want.new_handle = nh;
      dir_rows.push_back(row);
   endtask

   // called just after a falling edge; returns just after a falling edge once the request has been taken
   task automatic send_request(input counter_req_t r);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= r.mode;
      req_handle <= r.handle;
      req_value <= r.value;
      req_open_flags <= r.open_flags;
      req_length_bytes <= r.length_bytes;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(negedge clock)
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

   always @(posedge clock) begin : monitor
      counter_req_t   seen;
      counter_reply_t want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen.mode = mode_type'(req_mode);
            seen.handle = req_handle;
            seen.value = req_value;
            seen.open_flags = req_open_flags;
            seen.length_bytes = req_length_bytes;
            want = counter_table_op(seen);
            replies_due.push_back(typed_now ? want_now : want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               $display("%0t: reply transfer with none expected, status %0d",
                        $time, rsp_status);
               errors++;
            end else begin
               want = replies_due.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_status));
               check_field("new_handle", 64'(want.new_handle), 64'(rsp_new_handle));
               check_field("read_value", want.read_value, rsp_read_value);
               check_field("readable", 64'(want.readable), 64'(rsp_readable));
               check_field("writable", 64'(want.writable), 64'(rsp_writable));
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         slot_live[i] = 1'b0;
         slot_count[i] = 64'd0;
         slot_nonblk[i] = 1'b0;
         slot_sem[i] = 1'b0;
      end

      // empty table: every handle is unknown
      add_row(MODE_QUERY, 16'd256, 64'd0, 2'd0, 4'd8, 1'b1, STATUS_INVALID, 16'd0);
      add_row(MODE_READ, 16'd255, 64'd0, 2'd0, 4'd15, 1'b1, STATUS_INVALID, 16'd0);
      add_row(MODE_WRITE, 16'hffff, 64'd1, 2'd0, 4'd8, 1'b1, STATUS_INVALID, 16'd0);
      // creates: handle ignored, only the low word of the value loads
      add_row(MODE_CREATE, 16'hffff, 64'hffff_ffff_0000_0005, 2'd0, 4'd0, 1'b1, STATUS_OK,
              16'd256);
      add_row(MODE_CREATE, 16'd0, 64'd0, 2'd1, 4'd0, 1'b1, STATUS_OK, 16'd257);
      add_row(MODE_CREATE, 16'd0, 64'h0000_0000_ffff_ffff, 2'd2, 4'd15, 1'b1, STATUS_OK,
              16'd258);
      add_row(MODE_CREATE, 16'd0, 64'd0, 2'd3, 4'd7, 1'b1, STATUS_OK, 16'd259);
      // reads: short buffer, plain, empty blocking, empty nonblocking, semaphore
      add_row(MODE_READ, 16'd256, 64'd0, 2'd0, 4'd7, 1'b1, STATUS_INVALID, 16'd0);
      add_row(MODE_READ, 16'd256, '1, 2'd3, 4'd15, 1'b0, STATUS_OK, 16'd0);
      add_row(MODE_READ, 16'd256, 64'd0, 2'd0, 4'd8, 1'b1, STATUS_RETRY, 16'd0);
      add_row(MODE_READ, 16'd257, 64'd0, 2'd0, 4'd8, 1'b1, STATUS_WOULD_BLOCK, 16'd0);
      add_row(MODE_READ, 16'd258, 64'd0, 2'd0, 4'd8, 1'b0, STATUS_OK, 16'd0);
      add_row(MODE_READ, 16'd259, 64'd0, 2'd0, 4'd8, 1'b1, STATUS_WOULD_BLOCK, 16'd0);
      // writes: all-ones, short buffer, fill to the top, overflow both ways
      add_row(MODE_WRITE, 16'd256, '1, 2'd0, 4'd8, 1'b1, STATUS_INVALID, 16'd0);
      add_row(MODE_WRITE, 16'd256, 64'd1, 2'd0, 4'd7, 1'b1, STATUS_INVALID, 16'd0);
      add_row(MODE_WRITE, 16'd256, COUNT_MAX, 2'd3, 4'd15, 1'b0, STATUS_OK, 16'd0);
      add_row(MODE_QUERY, 16'd256, '1, 2'd3, 4'd0, 1'b0, STATUS_OK, 16'd0);
      add_row(MODE_WRITE, 16'd256, 64'd1, 2'd0, 4'd8, 1'b1, STATUS_RETRY, 16'd0);
      add_row(MODE_WRITE, 16'd257, COUNT_MAX, 2'd0, 4'd8, 1'b0, STATUS_OK, 16'd0);
      add_row(MODE_WRITE, 16'd257, 64'd1, 2'd0, 4'd8, 1'b1, STATUS_WOULD_BLOCK, 16'd0);
      add_row(MODE_WRITE, 16'd256, 64'd0, 2'd0, 4'd8, 1'b0, STATUS_OK, 16'd0);
      add_row(MODE_QUERY, 16'd259, 64'd0, 2'd0, 4'd8, 1'b0, STATUS_OK, 16'd0);
      add_row(MODE_QUERY, 16'd260, 64'd0, 2'd0, 4'd8, 1'b1, STATUS_INVALID, 16'd0);
      add_row(MODE_QUERY, 16'd320, 64'd0, 2'd0, 4'd8, 1'b1, STATUS_INVALID, 16'd0);
      add_row(MODE_READ, 16'd256, 64'd0, 2'd0, 4'd15, 1'b0, STATUS_OK, 16'd0);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         typed_now = dir_rows[i].typed;
         want_now = dir_rows[i].want;
         send_request(dir_rows[i].req);
      end
      typed_now = 1'b0;
      for (int n = 0; n < N_RANDOM; n++) begin
         calm = (n >= 900 && n < 1200);
         send_request(random_request());
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (replies_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("%0t: timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
